FILE: rtl/core/lpft_pkg.sv
package lpft_pkg;

  // Point and result field widths
  localparam int COORD_BITS     = 20;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int OUT_W          = 22;
  localparam int POS_W          = 21;
  localparam int QLANE_W        = 16;

  // Configuration register widths
  localparam int KEEP_W     = 8;
  localparam int BLIND_W    = 16;
  localparam int QUAT_REG_W = 4 * QLANE_W;
  localparam int POS_REG_W  = 3 * POS_W;

  // APB-style port: registers on 8-byte boundaries
  localparam int APB_DW    = 64;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_LSB  = 3;
  localparam int APB_AW    = REG_IDX_W + ADDR_LSB;

  localparam logic [REG_IDX_W-1:0] REG_KEEP_EVERY = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BLIND      = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ATTITUDE   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_VEH_POS    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_ORG_POS    = REG_IDX_W'(4);

  localparam logic [KEEP_W-1:0]     KEEP_EVERY_RST = KEEP_W'(3);
  localparam logic [BLIND_W-1:0]    BLIND_RST      = BLIND_W'(500);
  localparam logic [QUAT_REG_W-1:0] ATTITUDE_RST   = QUAT_REG_W'(1 << QUAT_FRAC_BITS);

  // Squared range compare width
  localparam int SQ_W = (2 * COORD_BITS + 1 > 2 * BLIND_W) ? 2 * COORD_BITS + 1 : 2 * BLIND_W;

  // Rotation matrix arithmetic
  localparam int QP_W  = 2 * QLANE_W;
  localparam int PRE_W = ((2 * QUAT_FRAC_BITS + 2 > QP_W + 3) ?
                          2 * QUAT_FRAC_BITS + 2 : QP_W + 3) + 1;
  localparam int R_W   = PRE_W - QUAT_FRAC_BITS;
  localparam int F_W   = COORD_BITS + 1;
  localparam int P_W   = R_W + F_W;
  localparam int ACC_W = P_W + 2;
  localparam int NED_W = ACC_W + 2;

  // Front-to-back queue
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]      out_coord_t;
  typedef logic signed [R_W-1:0]        rot_entry_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   kept;
    logic   last;
  } pt_item_t;

  typedef struct packed {
    logic [KEEP_W-1:0]    keep_every;
    logic [BLIND_W-1:0]   blind_radius_mm;
    rot_entry_t [2:0][2:0] rmat;
    logic [POS_REG_W-1:0] vehicle_pos;
    logic [POS_REG_W-1:0] origin_pos;
  } cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ACC,
    B_OUT
  } back_state_e;

  function automatic out_coord_t sat_out(input logic signed [NED_W-1:0] v);
    logic signed [NED_W-1:0] hi;
    logic signed [NED_W-1:0] lo;
    hi = {{(NED_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[OUT_W-1:0];
    end else if (v < lo) begin
      return lo[OUT_W-1:0];
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/lpft_if.sv
interface lpft_pt_if;
  import lpft_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pt_x;
  coord_t pt_y;
  coord_t pt_z;
  logic   pt_finite;
  logic   cloud_end;

  modport source (output valid, output pt_x, output pt_y, output pt_z,
                  output pt_finite, output cloud_end, input ready);
  modport sink   (input valid, input pt_x, input pt_y, input pt_z,
                  input pt_finite, input cloud_end, output ready);
endinterface

interface lpft_res_if;
  import lpft_pkg::*;

  logic       valid;
  logic       ready;
  out_coord_t out_east;
  out_coord_t out_north;
  out_coord_t out_up;
  logic       kept;
  logic       out_cloud_end;

  modport source (output valid, output out_east, output out_north, output out_up,
                  output kept, output out_cloud_end, input ready);
  modport sink   (input valid, input out_east, input out_north, input out_up,
                  input kept, input out_cloud_end, output ready);
endinterface

FILE: rtl/core/lpft_cfg.sv
module lpft_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpft_pkg::APB_AW-1:0]  paddr,
  input  logic [lpft_pkg::APB_DW-1:0]  pwdata,
  output logic [lpft_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output lpft_pkg::cfg_t               cfg_o
);
  import lpft_pkg::*;

  logic [KEEP_W-1:0]     keep_every_q;
  logic [BLIND_W-1:0]    blind_q;
  logic [QUAT_REG_W-1:0] quat_q;
  logic [POS_REG_W-1:0]  veh_q;
  logic [POS_REG_W-1:0]  org_q;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic signed [QLANE_W-1:0] qw, qx, qy, qz;
  logic signed [QP_W-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q, pwx_q, pwy_q, pwz_q;
  logic signed [PRE_W-1:0] one2;
  rot_entry_t [2:0][2:0] rmat_d, rmat_q;

  function automatic logic signed [PRE_W-1:0] ext(input logic signed [QP_W-1:0] v);
    return PRE_W'(v);
  endfunction

  // Round half up from Q(2F) to QF
  function automatic rot_entry_t rnd(input logic signed [PRE_W-1:0] v);
    logic signed [PRE_W-1:0] half;
    logic signed [PRE_W-1:0] t;
    half = '0;
    half[QUAT_FRAC_BITS-1] = 1'b1;
    t = (v + half) >>> QUAT_FRAC_BITS;
    return t[R_W-1:0];
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:ADDR_LSB];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_every_q <= KEEP_EVERY_RST;
      blind_q      <= BLIND_RST;
      quat_q       <= ATTITUDE_RST;
      veh_q        <= '0;
      org_q        <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEEP_EVERY: keep_every_q <= pwdata[KEEP_W-1:0];
        REG_BLIND:      blind_q      <= pwdata[BLIND_W-1:0];
        REG_ATTITUDE:   quat_q       <= pwdata[QUAT_REG_W-1:0];
        REG_VEH_POS:    veh_q        <= pwdata[POS_REG_W-1:0];
        REG_ORG_POS:    org_q        <= pwdata[POS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_KEEP_EVERY: prdata = APB_DW'(keep_every_q);
      REG_BLIND:      prdata = APB_DW'(blind_q);
      REG_ATTITUDE:   prdata = APB_DW'(quat_q);
      REG_VEH_POS:    prdata = APB_DW'(veh_q);
      REG_ORG_POS:    prdata = APB_DW'(org_q);
      default:        prdata = '0;
    endcase
  end

  assign qw = quat_q[0*QLANE_W +: QLANE_W];
  assign qx = quat_q[1*QLANE_W +: QLANE_W];
  assign qy = quat_q[2*QLANE_W +: QLANE_W];
  assign qz = quat_q[3*QLANE_W +: QLANE_W];

  // Matrix tracks the attitude register through the product and matrix registers
  always_ff @(posedge clk_i) begin
    pxx_q <= qx * qx;
    pyy_q <= qy * qy;
    pzz_q <= qz * qz;
    pxy_q <= qx * qy;
    pxz_q <= qx * qz;
    pyz_q <= qy * qz;
    pwx_q <= qw * qx;
    pwy_q <= qw * qy;
    pwz_q <= qw * qz;
  end

  always_comb begin
    one2 = '0;
    one2[2*QUAT_FRAC_BITS] = 1'b1;
    rmat_d[0][0] = rnd(one2 - ((ext(pyy_q) + ext(pzz_q)) <<< 1));
    rmat_d[0][1] = rnd((ext(pxy_q) - ext(pwz_q)) <<< 1);
    rmat_d[0][2] = rnd((ext(pxz_q) + ext(pwy_q)) <<< 1);
    rmat_d[1][0] = rnd((ext(pxy_q) + ext(pwz_q)) <<< 1);
    rmat_d[1][1] = rnd(one2 - ((ext(pxx_q) + ext(pzz_q)) <<< 1));
    rmat_d[1][2] = rnd((ext(pyz_q) - ext(pwx_q)) <<< 1);
    rmat_d[2][0] = rnd((ext(pxz_q) - ext(pwy_q)) <<< 1);
    rmat_d[2][1] = rnd((ext(pyz_q) + ext(pwx_q)) <<< 1);
    rmat_d[2][2] = rnd(one2 - ((ext(pxx_q) + ext(pyy_q)) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    rmat_q <= rmat_d;
  end

  always_comb begin
    cfg_o.keep_every      = keep_every_q;
    cfg_o.blind_radius_mm = blind_q;
    cfg_o.rmat            = rmat_q;
    cfg_o.vehicle_pos     = veh_q;
    cfg_o.origin_pos      = org_q;
  end

endmodule

FILE: rtl/core/lpft_front.sv
module lpft_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  lpft_pt_if.sink            pt_i,
  input  lpft_pkg::cfg_t     cfg_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output lpft_pkg::pt_item_t push_item_o
);
  import lpft_pkg::*;

  function automatic logic [COORD_BITS-1:0] mag(input coord_t v);
    return v[COORD_BITS-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
  endfunction

  logic [KEEP_W-1:0] phase_q, phase_d;
  logic [KEEP_W-1:0] every;
  logic [KEEP_W:0]   phase_inc;
  logic              accept;
  logic              s2_free;

  logic   v1_q, v2_q;
  coord_t x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic   elig1_q, last1_q, elig2_q, last2_q;

  logic [2*COORD_BITS-1:0] mx, my, mz;
  logic [2*COORD_BITS-1:0] sqx_q, sqy_q, sqz_q;
  logic [2*BLIND_W-1:0]    br_w, br2_q;
  logic [SQ_W-1:0]         sq_sum;

  assign s2_free  = !v2_q || push_ready_i;
  assign pt_i.ready = !v1_q || s2_free;
  assign accept   = pt_i.valid && pt_i.ready;

  // A keep_every of zero behaves as one
  assign every     = (cfg_i.keep_every == '0) ? KEEP_W'(1) : cfg_i.keep_every;
  assign phase_inc = {1'b0, phase_q} + (KEEP_W+1)'(1);
  assign phase_d   = (phase_inc >= {1'b0, every} || pt_i.cloud_end) ?
                     '0 : phase_inc[KEEP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
      end
      if (accept) begin
        v1_q <= 1'b1;
      end else if (s2_free) begin
        v1_q <= 1'b0;
      end
      if (v1_q && s2_free) begin
        v2_q <= 1'b1;
      end else if (push_ready_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q    <= pt_i.pt_x;
      y1_q    <= pt_i.pt_y;
      z1_q    <= pt_i.pt_z;
      elig1_q <= (phase_q == '0) && pt_i.pt_finite;
      last1_q <= pt_i.cloud_end;
    end
  end

  assign mx   = {{COORD_BITS{1'b0}}, mag(x1_q)};
  assign my   = {{COORD_BITS{1'b0}}, mag(y1_q)};
  assign mz   = {{COORD_BITS{1'b0}}, mag(z1_q)};
  assign br_w = {{BLIND_W{1'b0}}, cfg_i.blind_radius_mm};

  always_ff @(posedge clk_i) begin
    if (v1_q && s2_free) begin
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      z2_q    <= z1_q;
      elig2_q <= elig1_q;
      last2_q <= last1_q;
      sqx_q   <= mx * mx;
      sqy_q   <= my * my;
      sqz_q   <= mz * mz;
      br2_q   <= br_w * br_w;
    end
  end

  assign sq_sum = SQ_W'(sqx_q) + SQ_W'(sqy_q) + SQ_W'(sqz_q);

  assign push_valid_o     = v2_q;
  assign push_item_o.x    = x2_q;
  assign push_item_o.y    = y2_q;
  assign push_item_o.z    = z2_q;
  assign push_item_o.kept = elig2_q && (sq_sum > SQ_W'(br2_q));
  assign push_item_o.last = last2_q;

endmodule

FILE: rtl/core/lpft_fifo.sv
module lpft_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  lpft_pkg::pt_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output lpft_pkg::pt_item_t pop_item_o
);
  import lpft_pkg::*;

  pt_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]   count_q;
  logic                 do_push, do_pop;

  assign push_ready_o = (count_q != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - FIFO_CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/lpft_back.sv
module lpft_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_o,
  input  lpft_pkg::pt_item_t pop_item_i,
  input  lpft_pkg::cfg_t     cfg_i,
  lpft_res_if.source         res_o
);
  import lpft_pkg::*;

  localparam logic [1:0] ROW_NORTH = 2'd0;
  localparam logic [1:0] ROW_EAST  = 2'd1;
  localparam logic [1:0] ROW_DOWN  = 2'd2;

  back_state_e state_q, state_d;
  logic [1:0]  row_q;
  logic        mul_en, acc_en, out_load, out_free;

  logic signed [F_W-1:0] fx_q, fy_q, fz_q;
  logic                  kept_q, last_q;
  logic signed [P_W-1:0] prod0_q, prod1_q, prod2_q;
  logic signed [P_W-1:0] rc0, rc1, rc2;

  logic signed [ACC_W-1:0] acc, half, rounded;
  logic signed [POS_W-1:0] veh, org;
  logic signed [NED_W-1:0] ned;

  out_coord_t res_n_q, res_e_q, res_u_q;
  logic       out_valid_q;
  out_coord_t out_e_q, out_n_q, out_u_q;
  logic       out_kept_q, out_last_q;

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_item_i.kept ? B_MUL : B_OUT;
        end
      end
      B_MUL: state_d = B_ACC;
      B_ACC: state_d = (row_q == ROW_DOWN) ? B_OUT : B_MUL;
      B_OUT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mul_en   = 1'b0;
    acc_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      B_IDLE:  pop_o    = pop_valid_i;
      B_MUL:   mul_en   = 1'b1;
      B_ACC:   acc_en   = 1'b1;
      B_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      row_q   <= ROW_NORTH;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        row_q <= ROW_NORTH;
      end else if (acc_en) begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  // One row of the rotation per multiply/accumulate pair
  assign rc0 = P_W'($signed(cfg_i.rmat[row_q][0]));
  assign rc1 = P_W'($signed(cfg_i.rmat[row_q][1]));
  assign rc2 = P_W'($signed(cfg_i.rmat[row_q][2]));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      // FLU to FRD
      fx_q   <= F_W'(pop_item_i.x);
      fy_q   <= -F_W'(pop_item_i.y);
      fz_q   <= -F_W'(pop_item_i.z);
      kept_q <= pop_item_i.kept;
      last_q <= pop_item_i.last;
    end
    if (mul_en) begin
      prod0_q <= rc0 * P_W'(fx_q);
      prod1_q <= rc1 * P_W'(fy_q);
      prod2_q <= rc2 * P_W'(fz_q);
    end
  end

  always_comb begin
    half = '0;
    half[QUAT_FRAC_BITS-1] = 1'b1;
    acc     = ACC_W'(prod0_q) + ACC_W'(prod1_q) + ACC_W'(prod2_q);
    rounded = (acc + half) >>> QUAT_FRAC_BITS;
    veh     = cfg_i.vehicle_pos[POS_W*row_q +: POS_W];
    org     = cfg_i.origin_pos[POS_W*row_q +: POS_W];
    ned     = NED_W'(rounded) + NED_W'(veh) - NED_W'(org);
  end

  // NED to ENU happens on the way into the result registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_n_q <= '0;
      res_e_q <= '0;
      res_u_q <= '0;
    end else if (acc_en) begin
      case (row_q)
        ROW_NORTH: res_n_q <= sat_out(ned);
        ROW_EAST:  res_e_q <= sat_out(ned);
        ROW_DOWN:  res_u_q <= sat_out(-ned);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_e_q    <= res_e_q;
      out_n_q    <= res_n_q;
      out_u_q    <= res_u_q;
      out_kept_q <= kept_q;
      out_last_q <= last_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.out_east      = out_e_q;
  assign res_o.out_north     = out_n_q;
  assign res_o.out_up        = out_u_q;
  assign res_o.kept          = out_kept_q;
  assign res_o.out_cloud_end = out_last_q;

endmodule

FILE: rtl/core/lidar_point_filter_transform.sv
// Lidar point filter and transform.
// pt_i takes one FLU point (mm) per transfer with a finite flag and a
// last-of-cloud mark; res_o returns exactly one result per point, in order:
// relative ENU coordinates (mm, saturated to 22 bits), a kept flag and the
// copied last-of-cloud mark. Dropped points (decimated, not finite, or inside
// the blind radius) come out with kept low and zero coordinates.
// The front stage decimates and range-gates through its input and square
// registers and can take a point every cycle into a 4-entry queue unless
// that queue is full. The back stage rotates with one set of three
// multipliers reused across the three rows (B_MUL then B_ACC per row, then
// B_OUT; a dropped point goes straight to B_OUT) and pops the next point
// only after the current one has left B_OUT.
// Configuration goes through the APB-style port (registers at 8-byte
// steps); write only while the block holds no points. The rotation matrix
// follows an attitude write through the product and matrix registers.
// Reset clears the decimation phase, the queue and the valid flags and loads
// the register defaults. A stalled receiver holds the result register, the
// back stage then waits, the queue fills and pt_i.ready drops.
module lidar_point_filter_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpft_pkg::APB_AW-1:0]  paddr,
  input  logic [lpft_pkg::APB_DW-1:0]  pwdata,
  output logic [lpft_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  lpft_pt_if.sink                      pt_i,
  lpft_res_if.source                   res_o
);
  import lpft_pkg::*;

  cfg_t     cfg;
  logic     push_valid, push_ready;
  pt_item_t push_item;
  logic     pop_valid, pop;
  pt_item_t pop_item;

  lpft_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lpft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pt_i         (pt_i),
    .cfg_i        (cfg),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  lpft_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  lpft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .cfg_i       (cfg),
    .res_o       (res_o)
  );

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.kept) |->
      (res_o.out_east == '0 && res_o.out_north == '0 && res_o.out_up == '0))
    else $error("dropped point carries nonzero coordinates");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("back stage popped an empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && !push_ready) |=> push_valid)
    else $error("front stage lost a point while the queue was full");

endmodule
